@@ src/stt_pkg.sv @@
// Shared constants, token kind codes and result type for the source text tokenizer.
`timescale 1ns / 1ps

package stt_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int LINE_BITS   = 20;
  localparam int KIND_BITS   = 5;

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]   LINE_MAX   = {LINE_BITS{1'b1}};

  localparam logic [KIND_BITS-1:0] KIND_IDENT    = 5'd0;
  localparam logic [KIND_BITS-1:0] KIND_NUMBER   = 5'd1;
  localparam logic [KIND_BITS-1:0] KIND_STRING   = 5'd2;
  localparam logic [KIND_BITS-1:0] KIND_KW_INT   = 5'd3;
  localparam logic [KIND_BITS-1:0] KIND_KW_FUNC  = 5'd4;
  localparam logic [KIND_BITS-1:0] KIND_KW_STR   = 5'd5;
  localparam logic [KIND_BITS-1:0] KIND_PLUS     = 5'd6;
  localparam logic [KIND_BITS-1:0] KIND_MINUS    = 5'd7;
  localparam logic [KIND_BITS-1:0] KIND_STAR     = 5'd8;
  localparam logic [KIND_BITS-1:0] KIND_SLASH    = 5'd9;
  localparam logic [KIND_BITS-1:0] KIND_ASSIGN   = 5'd10;
  localparam logic [KIND_BITS-1:0] KIND_LPAREN   = 5'd11;
  localparam logic [KIND_BITS-1:0] KIND_RPAREN   = 5'd12;
  localparam logic [KIND_BITS-1:0] KIND_LBRACE   = 5'd13;
  localparam logic [KIND_BITS-1:0] KIND_RBRACE   = 5'd14;
  localparam logic [KIND_BITS-1:0] KIND_COMMA    = 5'd15;
  localparam logic [KIND_BITS-1:0] KIND_SEMI     = 5'd16;
  localparam logic [KIND_BITS-1:0] KIND_BAD_CHAR = 5'd17;
  localparam logic [KIND_BITS-1:0] KIND_UNTERM   = 5'd18;
  localparam logic [KIND_BITS-1:0] KIND_EOF      = 5'd19;

  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [OFFSET_BITS-1:0] offset;
    logic [OFFSET_BITS-1:0] len;
    logic [LINE_BITS-1:0]   line;
    logic                   last;
  } result_t;

endpackage

@@ src/source_text_tokenizer.sv @@
// Top level of the source text tokenizer: input register, scanner, result queue.
//
//  channel | direction | payload
//  in_     | input     | char_byte[7:0], is_end
//  out_    | output    | token_kind[4:0], token_offset[23:0], token_len[23:0],
//          |           | token_line[19:0], last_of_run
//
// One byte is taken per cycle unless the register is full and the queue lacks room; each
// byte is scanned from the input register. A token is queued when the byte that completes
// it is scanned; a token ended by lookahead (identifier, number, lone slash) completes on
// the byte after it. A byte that yields two tokens needs two output transactions; the
// four-entry queue lets input keep flowing while results wait.
// Synchronous active-low reset returns to offset 0, line 1, idle between tokens.
// Input stalls when the queue holds more than two tokens and the register is full.
`timescale 1ns / 1ps

module source_text_tokenizer import stt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_char_byte,
  input  logic                   in_is_end,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [KIND_BITS-1:0]   out_token_kind,
  output logic [OFFSET_BITS-1:0] out_token_offset,
  output logic [OFFSET_BITS-1:0] out_token_len,
  output logic [LINE_BITS-1:0]   out_token_line,
  output logic                   out_last_of_run
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;
  logic       room, step;
  logic [1:0] push_cnt;
  result_t    res0, res1, head;

  assign step     = s1_valid_r && room;
  assign in_ready = !s1_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_char_byte;
      s1_end_r  <= in_is_end;
    end
  end

  stt_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .char_byte (s1_byte_r),
    .is_end    (s1_end_r),
    .push_cnt  (push_cnt),
    .res0      (res0),
    .res1      (res1)
  );

  stt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (res0),
    .push1     (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_token_kind   = head.kind;
  assign out_token_offset = head.offset;
  assign out_token_len    = head.len;
  assign out_token_line   = head.line;
  assign out_last_of_run  = head.last;

endmodule

@@ src/stt_scan.sv @@
// Scanner state and the per-byte decision that produces up to two tokens.
`timescale 1ns / 1ps

module stt_scan import stt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] char_byte,
  input  logic       is_end,
  output logic [1:0] push_cnt,
  output result_t    res0,
  output result_t    res1
);

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_IDENT   = 3'd1;
  localparam logic [2:0] MODE_NUMBER  = 3'd2;
  localparam logic [2:0] MODE_STRING  = 3'd3;
  localparam logic [2:0] MODE_SLASH   = 3'd4;
  localparam logic [2:0] MODE_COMMENT = 3'd5;

  localparam logic [3:0] KW_NONE = 4'd0;
  localparam logic [3:0] KW_I    = 4'd1;
  localparam logic [3:0] KW_IN   = 4'd2;
  localparam logic [3:0] KW_INT  = 4'd3;
  localparam logic [3:0] KW_F    = 4'd4;
  localparam logic [3:0] KW_FU   = 4'd5;
  localparam logic [3:0] KW_FUN  = 4'd6;
  localparam logic [3:0] KW_FUNC = 4'd7;
  localparam logic [3:0] KW_S    = 4'd8;
  localparam logic [3:0] KW_ST   = 4'd9;
  localparam logic [3:0] KW_STR  = 4'd10;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_NUL   = 8'h00;

  function automatic logic [3:0] kw_next(input logic [3:0] p, input logic [7:0] c);
    logic [3:0] n;
    n = KW_NONE;
    case (p)
      KW_I:   if (c == "n") n = KW_IN;
      KW_IN:  if (c == "t") n = KW_INT;
      KW_F:   if (c == "u") n = KW_FU;
      KW_FU:  if (c == "n") n = KW_FUN;
      KW_FUN: if (c == "c") n = KW_FUNC;
      KW_S:   if (c == "t") n = KW_ST;
      KW_ST:  if (c == "r") n = KW_STR;
      default: n = KW_NONE;
    endcase
    return n;
  endfunction

  function automatic logic [KIND_BITS-1:0] kw_kind(input logic [3:0] p);
    logic [KIND_BITS-1:0] k;
    case (p)
      KW_INT:  k = KIND_KW_INT;
      KW_FUNC: k = KIND_KW_FUNC;
      KW_STR:  k = KIND_KW_STR;
      default: k = KIND_IDENT;
    endcase
    return k;
  endfunction

  function automatic logic [KIND_BITS-1:0] op_kind(input logic [7:0] c);
    logic [KIND_BITS-1:0] k;
    case (c)
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_STAR;
      "=":     k = KIND_ASSIGN;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      ",":     k = KIND_COMMA;
      ";":     k = KIND_SEMI;
      default: k = KIND_BAD_CHAR;
    endcase
    return k;
  endfunction

  logic [2:0]             mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] begin_r, begin_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [3:0]             kw_r, kw_nxt;

  logic                   text_end, is_alpha, is_digit, ident_char;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic [LINE_BITS-1:0]   line_inc;
  logic                   idle_path;
  logic                   flush_v, sec_v;
  logic [KIND_BITS-1:0]   flush_kind, sec_kind;
  logic [OFFSET_BITS-1:0] sec_off, sec_len;
  result_t                flush_res, sec_res;

  assign text_end   = is_end || (char_byte == CH_NUL);
  assign is_alpha   = ((char_byte >= "a") && (char_byte <= "z")) ||
                      ((char_byte >= "A") && (char_byte <= "Z"));
  assign is_digit   = (char_byte >= "0") && (char_byte <= "9");
  assign ident_char = is_alpha || is_digit || (char_byte == "_");
  assign pos_inc    = (pos_r == OFFSET_MAX) ? pos_r : pos_r + OFFSET_BITS'(1);
  assign line_inc   = (line_r == LINE_MAX) ? line_r : line_r + LINE_BITS'(1);

  always_comb begin
    unique case (mode_r)
      MODE_IDENT:  flush_kind = kw_kind(kw_r);
      MODE_NUMBER: flush_kind = KIND_NUMBER;
      MODE_SLASH:  flush_kind = KIND_SLASH;
      MODE_STRING: flush_kind = KIND_UNTERM;
      default:     flush_kind = KIND_BAD_CHAR;
    endcase
  end

  always_comb begin
    mode_nxt  = mode_r;
    begin_nxt = begin_r;
    pos_nxt   = pos_r;
    line_nxt  = line_r;
    kw_nxt    = kw_r;
    idle_path = 1'b0;
    flush_v   = 1'b0;
    sec_v     = 1'b0;
    sec_kind  = KIND_EOF;
    sec_off   = pos_r;
    sec_len   = '0;

    if (text_end) begin
      flush_v   = (mode_r == MODE_IDENT) || (mode_r == MODE_NUMBER) ||
                  (mode_r == MODE_SLASH) || (mode_r == MODE_STRING);
      sec_v     = 1'b1;
      mode_nxt  = MODE_IDLE;
      begin_nxt = '0;
      pos_nxt   = '0;
      line_nxt  = LINE_BITS'(1);
      kw_nxt    = KW_NONE;
    end else begin
      unique case (mode_r)
        MODE_IDENT: begin
          if (ident_char) begin
            kw_nxt  = kw_next(kw_r, char_byte);
            pos_nxt = pos_inc;
          end else begin
            flush_v   = 1'b1;
            idle_path = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_digit) begin
            pos_nxt = pos_inc;
          end else begin
            flush_v   = 1'b1;
            idle_path = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (char_byte == "/") begin
            mode_nxt = MODE_COMMENT;
            pos_nxt  = pos_inc;
          end else begin
            flush_v   = 1'b1;
            idle_path = 1'b1;
          end
        end
        MODE_STRING: begin
          if (char_byte == CH_LF) line_nxt = line_inc;
          pos_nxt = pos_inc;
          if (char_byte == CH_QUOTE) begin
            sec_v    = 1'b1;
            sec_kind = KIND_STRING;
            sec_off  = begin_r;
            sec_len  = pos_inc - begin_r;
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_COMMENT: begin
          if (char_byte == CH_LF) begin
            line_nxt = line_inc;
            mode_nxt = MODE_IDLE;
          end
          pos_nxt = pos_inc;
        end
        default: idle_path = 1'b1;
      endcase

      if (idle_path) begin
        mode_nxt  = MODE_IDLE;
        begin_nxt = pos_r;
        pos_nxt   = pos_inc;
        if ((char_byte == CH_SPACE) || (char_byte == CH_CR) || (char_byte == CH_TAB)) begin
          mode_nxt = MODE_IDLE;
        end else if (char_byte == CH_LF) begin
          line_nxt = line_inc;
        end else if (is_alpha) begin
          mode_nxt = MODE_IDENT;
          kw_nxt   = (char_byte == "i") ? KW_I :
                     (char_byte == "f") ? KW_F :
                     (char_byte == "s") ? KW_S : KW_NONE;
        end else if (is_digit) begin
          mode_nxt = MODE_NUMBER;
        end else if (char_byte == "/") begin
          mode_nxt = MODE_SLASH;
        end else if (char_byte == CH_QUOTE) begin
          mode_nxt = MODE_STRING;
        end else begin
          sec_v    = 1'b1;
          sec_kind = op_kind(char_byte);
          sec_off  = pos_r;
          sec_len  = pos_inc - pos_r;
        end
      end
    end
  end

  // Pending token goes out ahead of whatever the current byte produces.
  always_comb begin
    flush_res.kind   = flush_kind;
    flush_res.offset = begin_r;
    flush_res.len    = pos_r - begin_r;
    flush_res.line   = line_r;
    flush_res.last   = !sec_v;
    sec_res.kind     = sec_kind;
    sec_res.offset   = sec_off;
    sec_res.len      = sec_len;
    sec_res.line     = line_r;
    sec_res.last     = 1'b1;
    res0     = flush_v ? flush_res : sec_res;
    res1     = sec_res;
    push_cnt = step ? (2'(flush_v) + 2'(sec_v)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      begin_r <= '0;
      pos_r   <= '0;
      line_r  <= LINE_BITS'(1);
      kw_r    <= KW_NONE;
    end else if (step) begin
      mode_r  <= mode_nxt;
      begin_r <= begin_nxt;
      pos_r   <= pos_nxt;
      line_r  <= line_nxt;
      kw_r    <= kw_nxt;
    end
  end

endmodule

@@ src/stt_fifo.sv @@
// Result queue: takes up to two tokens per cycle, hands out one per transaction.
`timescale 1ns / 1ps

module stt_fifo import stt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_cnt,
  input  result_t    push0,
  input  result_t    push1,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    head
);

  result_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wp_r, wp_nxt;
  logic [FIFO_PTR_BITS-1:0] rp_r, rp_nxt;
  logic [FIFO_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                     pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign head      = mem_r[rp_r];
  assign room      = (cnt_r <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
  assign wp_nxt    = wp_r + FIFO_PTR_BITS'(push_cnt);
  assign rp_nxt    = rp_r + FIFO_PTR_BITS'(pop);
  assign cnt_nxt   = cnt_r + FIFO_CNT_BITS'(push_cnt) - FIFO_CNT_BITS'(pop);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem_r[wp_r] <= push0;
    if (push_cnt == 2'd2) mem_r[wp_r + FIFO_PTR_BITS'(1)] <= push1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ src/stt_checker.sv @@
// Port-level assertions for the source text tokenizer and their bind.
`timescale 1ns / 1ps

module stt_checker import stt_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [KIND_BITS-1:0]   out_token_kind,
  input logic [OFFSET_BITS-1:0] out_token_offset,
  input logic [OFFSET_BITS-1:0] out_token_len,
  input logic [LINE_BITS-1:0]   out_token_line,
  input logic                   out_last_of_run
);

  // Stalled transaction holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_kind) &&
    $stable(out_token_offset) && $stable(out_token_len) &&
    $stable(out_token_line) && $stable(out_last_of_run))
    else $error("result changed while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_token_kind <= KIND_EOF)
    else $error("token kind out of range");

  a_eof_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == KIND_EOF |-> out_token_len == '0 && out_last_of_run)
    else $error("end of text token malformed");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_token_line != '0)
    else $error("line count is zero");

  // An idle input register never stalls input: ready that is high while no byte is offered stays high.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid && in_ready |=> in_ready)
    else $error("input stalled with empty input register");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_token_kind   (out_token_kind),
  .out_token_offset (out_token_offset),
  .out_token_len    (out_token_len),
  .out_token_line   (out_token_line),
  .out_last_of_run  (out_last_of_run)
);
